@@ sv/rcd_pkg.sv @@
// Shared types and constants for the radio command decoder.
package rcd_pkg;

  // Input word kinds on the slave tuser lane.
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_EOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WAYPOINT_CNT  = 2'd1;
  localparam logic [1:0] CFG_INDEX_REPEATS = 2'd2;
  localparam logic [1:0] CFG_PERM_MASKS    = 2'd3;

  localparam logic [7:0]  TIMEOUT_RST = 8'd30;
  localparam logic [7:0]  WAYPOINT_RST = 8'd16;
  localparam logic [7:0]  REPEATS_RST = 8'd3;
  localparam logic [47:0] MASKS_RST = 48'hFF08_1404_0418;

  localparam int NUM_CMDS     = 9;
  localparam int CMD_NAME_MAX = 6;

  typedef enum logic [3:0] {
    CMD_IDLE   = 4'd0,
    CMD_MANUAL = 4'd1,
    CMD_AUTO   = 4'd2,
    CMD_INDEX  = 4'd3,
    CMD_RP     = 4'd4,
    CMD_RN     = 4'd5,
    CMD_LP     = 4'd6,
    CMD_LN     = 4'd7,
    CMD_PING   = 4'd8
  } cmd_code_e;

  // Command names, one character per byte, first character at index 0.
  localparam logic [7:0] CMD_NAMES [NUM_CMDS][CMD_NAME_MAX] = '{
    '{"i", "d", "l", "e", 8'h00, 8'h00},
    '{"m", "a", "n", "u", "a", "l"},
    '{"a", "u", "t", "o", 8'h00, 8'h00},
    '{"i", "n", "d", "e", "x", 8'h00},
    '{"R", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "i", "n", "g", 8'h00, 8'h00}
  };
  localparam int CMD_LENS [NUM_CMDS] = '{4, 6, 4, 5, 2, 2, 2, 2, 4};
  // Which permission mask byte governs each command.
  localparam logic [2:0] CMD_SLOT [NUM_CMDS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5
  };

  typedef logic [5:0][7:0] perm_masks_t;

  typedef enum logic [2:0] {
    KIND_ZERO   = 3'd0,
    KIND_DIGIT  = 3'd1,
    KIND_LETTER = 3'd2,
    KIND_OTHER  = 3'd3,
    KIND_EOP    = 3'd4,
    KIND_TICK   = 3'd5,
    KIND_NOP    = 3'd6
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
    logic [2:0] sys_state;
  } item_t;

  // Queue read side toward the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

@@ sv/rcd_front.sv @@
// Front end: accepts input words and classifies payload bytes.
module rcd_front import rcd_pkg::*; (
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_i,
  input  logic [2:0]  sys_state_i,
  output item_t       item_o
);

  logic is_digit;
  logic is_letter;

  assign is_digit  = (data_i >= "0") && (data_i <= "9");
  assign is_letter = ((data_i >= "a") && (data_i <= "z")) ||
                     ((data_i >= "A") && (data_i <= "Z"));

  always_comb begin
    item_o.data      = data_i;
    item_o.sys_state = sys_state_i;
    case (func_i)
      FUNC_BYTE: begin
        if (data_i == 8'h00) begin
          item_o.kind = KIND_ZERO;
        end else if (is_digit) begin
          item_o.kind = KIND_DIGIT;
        end else if (is_letter) begin
          item_o.kind = KIND_LETTER;
        end else begin
          item_o.kind = KIND_OTHER;
        end
      end
      FUNC_EOP:  item_o.kind = KIND_EOP;
      FUNC_TICK: item_o.kind = KIND_TICK;
      default:   item_o.kind = KIND_NOP;
    endcase
  end

endmodule

@@ sv/rcd_fifo.sv @@
// Short register queue between the front and back ends.
module rcd_fifo import rcd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t          entries_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/rcd_back.sv @@
// Back end: parser state, command match, debounce, heartbeat and result register.
module rcd_back import rcd_pkg::*; #(
  parameter int MAX_NAME_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  input  q_head_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        cmd_matched_o,
  output logic [3:0]  cmd_code_o,
  output logic [7:0]  cmd_arg_o,
  output logic        index_updated_o,
  output logic [7:0]  wp_target_o,
  output logic        connected_o
);

  // Length saturates at MAX_NAME_LEN + 1.
  localparam int LW = $clog2(MAX_NAME_LEN + 2);

  // Config
  logic [7:0]  timeout_q, waypoints_q, repeats_needed_q;
  perm_masks_t masks_q;

  // Parser and link state
  logic          name_phase_q, name_phase_d;
  logic          failed_q, failed_d;
  logic          ended_q, ended_d;
  logic [7:0]    name_chars_q [MAX_NAME_LEN];
  logic [LW-1:0] name_len_q, name_len_d;
  logic [7:0]    value_q, value_d;
  logic [7:0]    beat_q, beat_d;
  logic          link_q, link_d;
  logic [7:0]    last_idx_q, last_idx_d;
  logic [7:0]    rep_q, rep_d;
  logic          store_char;

  // Result register
  logic       out_valid_q;
  logic       matched_q, matched_d;
  cmd_code_e  code_q, code_d;
  logic [7:0] res_value_q, res_value_d;
  logic       upd_q, upd_d;
  logic [7:0] widx_q, widx_d;

  logic       take;
  logic       parse_live;
  logic [7:0] value_next;
  logic       found;
  cmd_code_e  found_code;
  logic [7:0] rep_new;
  item_t      it;

  assign it    = head_i.item;
  assign pop_o = !out_valid_q || out_ready_i;
  assign take  = head_i.valid && pop_o;

  assign parse_live = !ended_q && !failed_q;
  assign value_next = 8'({value_q, 3'b000} + {value_q, 1'b0}) + {4'h0, it.data[3:0]};
  assign store_char = take && (it.kind == KIND_LETTER) && parse_live && name_phase_q &&
                      (name_len_q < LW'(MAX_NAME_LEN));

  // Parallel compare of the stored name against every command name.
  always_comb begin
    logic eq;
    found      = 1'b0;
    found_code = CMD_IDLE;
    for (int k = 0; k < NUM_CMDS; k++) begin
      eq = (name_len_q == LW'(CMD_LENS[k])) && masks_q[CMD_SLOT[k]][it.sys_state];
      for (int i = 0; i < CMD_NAME_MAX; i++) begin
        if (i < CMD_LENS[k] && name_chars_q[i] != CMD_NAMES[k][i]) begin
          eq = 1'b0;
        end
      end
      if (eq && !found) begin
        found      = 1'b1;
        found_code = cmd_code_e'(4'(k));
      end
    end
    if (failed_q) begin
      found = 1'b0;
    end
  end

  assign rep_new = (value_q != last_idx_q) ? 8'd1 : rep_q + 8'd1;

  always_comb begin
    name_phase_d = name_phase_q;
    failed_d     = failed_q;
    ended_d      = ended_q;
    name_len_d   = name_len_q;
    value_d      = value_q;
    beat_d       = beat_q;
    link_d       = link_q;
    last_idx_d   = last_idx_q;
    rep_d        = rep_q;
    matched_d    = 1'b0;
    code_d       = CMD_IDLE;
    res_value_d  = 8'd0;
    upd_d        = 1'b0;
    widx_d       = 8'd0;
    case (it.kind)
      KIND_ZERO: begin
        if (parse_live) begin
          ended_d = 1'b1;
        end
      end
      KIND_DIGIT: begin
        if (parse_live) begin
          name_phase_d = 1'b0;
          value_d      = value_next;
        end
      end
      KIND_LETTER: begin
        if (parse_live) begin
          if (!name_phase_q) begin
            failed_d = 1'b1;
          end else if (name_len_q <= LW'(MAX_NAME_LEN)) begin
            name_len_d = name_len_q + 1'b1;
          end
        end
      end
      KIND_OTHER: begin
        if (parse_live) begin
          failed_d = 1'b1;
        end
      end
      KIND_EOP: begin
        if (found) begin
          matched_d   = 1'b1;
          code_d      = found_code;
          res_value_d = value_q;
          link_d      = 1'b1;
          beat_d      = 8'd0;
          if (found_code == CMD_INDEX) begin
            last_idx_d = value_q;
            rep_d      = rep_new;
            if (value_q < waypoints_q && rep_new >= repeats_needed_q) begin
              upd_d  = 1'b1;
              widx_d = value_q;
              rep_d  = 8'd0;
            end
          end
        end
        name_phase_d = 1'b1;
        failed_d     = 1'b0;
        ended_d      = 1'b0;
        name_len_d   = '0;
        value_d      = 8'd0;
      end
      KIND_TICK: begin
        if (beat_q >= timeout_q) begin
          link_d = 1'b0;
        end else begin
          beat_d = beat_q + 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q        <= TIMEOUT_RST;
      waypoints_q      <= WAYPOINT_RST;
      repeats_needed_q <= REPEATS_RST;
      masks_q          <= MASKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT_LIMIT: timeout_q        <= cfg_wdata_i[7:0];
        CFG_WAYPOINT_CNT:  waypoints_q      <= cfg_wdata_i[7:0];
        CFG_INDEX_REPEATS: repeats_needed_q <= cfg_wdata_i[7:0];
        CFG_PERM_MASKS:    masks_q          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_phase_q <= 1'b1;
      failed_q     <= 1'b0;
      ended_q      <= 1'b0;
      name_len_q   <= '0;
      value_q      <= 8'd0;
      beat_q       <= 8'd0;
      link_q       <= 1'b0;
      last_idx_q   <= 8'd0;
      rep_q        <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take) begin
        name_phase_q <= name_phase_d;
        failed_q     <= failed_d;
        ended_q      <= ended_d;
        name_len_q   <= name_len_d;
        value_q      <= value_d;
        beat_q       <= beat_d;
        link_q       <= link_d;
        last_idx_q   <= last_idx_d;
        rep_q        <= rep_d;
      end
      if (pop_o) begin
        out_valid_q <= head_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_NAME_LEN; i++) begin
      if (store_char && name_len_q == LW'(i)) begin
        name_chars_q[i] <= it.data;
      end
    end
    if (take) begin
      matched_q   <= matched_d;
      code_q      <= code_d;
      res_value_q <= res_value_d;
      upd_q       <= upd_d;
      widx_q      <= widx_d;
    end
  end

  // connected is the link status after the item; link_q holds it once taken.
  logic link_out_q;
  always_ff @(posedge clk_i) begin
    if (take) begin
      link_out_q <= link_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_matched_o   = matched_q;
  assign cmd_code_o      = code_q;
  assign cmd_arg_o       = res_value_q;
  assign index_updated_o = upd_q;
  assign wp_target_o     = widx_q;
  assign connected_o     = link_out_q;

endmodule

@@ sv/radio_command_decoder.sv @@
// Top level of the radio command decoder.
// Decodes ground-station text commands one byte word at a time: letters form the
// command name, digits fold into a value modulo 256, a zero byte ends the text, and an
// end-of-payload word (tuser 1) checks the name against nine commands under the
// permission mask of the current system state, producing exactly one result word per
// input word. Heartbeat ticks (tuser 2) age the link. Throughput is one word per clock
// while m_axis_tready does not stall the result; the back end updates the parser, match
// and debounce state once per word. A word is registered first in the short word queue
// that decouples the classifying front end from the back end, then in the result
// register. While a finished result waits on m_axis_tready the queue still takes up to
// QUEUE_DEPTH more words; after that s_axis_tready drops until the result leaves.
// Configuration writes take effect on the clock edge with cfg_we_i high and are meant
// for idle periods only.
module radio_command_decoder import rcd_pkg::*; #(
  parameter int MAX_NAME_LEN = 8,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data, [10:8] system_state, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [0] cmd_matched, [4:1] cmd_code, [12:5] cmd_arg,
                                     // [13] index_updated, [21:14] wp_target,
                                     // [22] connected, [23] zero
);

  item_t   front_item;
  logic    q_full;
  logic    q_pop;
  q_head_t q_head;

  logic       cmd_matched;
  logic [3:0] cmd_code;
  logic [7:0] cmd_arg;
  logic       index_updated;
  logic [7:0] wp_target;
  logic       connected;

  // Front end: classify the byte so the back end sees a kind code beside the data byte.
  rcd_front u_front (
    .func_i      (s_axis_tuser),
    .data_i      (s_axis_tdata[7:0]),
    .sys_state_i (s_axis_tdata[10:8]),
    .item_o      (front_item)
  );

  // Input is held off only when the queue is full.
  assign s_axis_tready = !q_full;

  rcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .item_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  // Back end: all decoder state plus the output register.
  rcd_back #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .cmd_matched_o   (cmd_matched),
    .cmd_code_o      (cmd_code),
    .cmd_arg_o       (cmd_arg),
    .index_updated_o (index_updated),
    .wp_target_o     (wp_target),
    .connected_o     (connected)
  );

  assign m_axis_tdata = {1'b0, connected, wp_target, index_updated,
                         cmd_arg, cmd_code, cmd_matched};

endmodule

@@ sv/rcd_checker.sv @@
// Port-level checks for the radio command decoder, bound to the top level.
module rcd_checker import rcd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No match means code and value read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("unmatched word carries code or value");

  // An index update comes only from a matched index command with the same value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |->
      m_axis_tdata[0] && m_axis_tdata[4:1] == CMD_INDEX &&
      m_axis_tdata[21:14] == m_axis_tdata[12:5])
    else $error("index update without matching index command");

  // Without an update the index field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[21:14] == 8'd0)
    else $error("waypoint index set without update");

  // A matched command always leaves the link up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[22])
    else $error("matched command but link down");

endmodule

bind radio_command_decoder rcd_checker u_rcd_checker (.*);
